>>> hdl/motor_current_rms_window_macros.svh
// Assertion macros shared by the motor current RMS window RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef MOTOR_CURRENT_RMS_WINDOW_MACROS_SVH
`define MOTOR_CURRENT_RMS_WINDOW_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MCRW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define MCRW_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MCRW_ASSERT(lbl, prop, msg)
`define MCRW_NEVER(lbl, expr, msg)
`endif
`endif

>>> hdl/mcrw_pkg.sv
package mcrw_pkg;

	localparam int SPW_DEFAULT = 10;

	localparam int RAW_W = 12;
	localparam int NUM_FIELDS = 6;
	localparam int CUR_W = 16;
	localparam int MV_W = 15;
	localparam int MAG_W = 15;
	localparam int SQ_W = 30;
	localparam int TERM_W = 33;
	localparam int RMS_W = 15;
	localparam int OFS_W = 13;
	localparam int NUM_W = 28;
	localparam int QUO_W = 16;

	localparam int FIFO_DEPTH = 2;

	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 160;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 8'd1;

	localparam int CUR_SCALE = 50000;
	localparam int CUR_BIAS = 25000;
	localparam int VOLT_SCALE = 20000;
	localparam int AUX_MID = 2048;
	// The root of the window sum is divided by 10, which equals dividing the
	// sum by 100 before taking the square root.
	localparam int RMS_DIV = 10;

	// Reciprocal of 4095: exact for every numerator below 2^28.
	localparam int RECIP_SH = 40;
	localparam int RECIP_W = 29;
	localparam logic [63:0] RECIP_4095_64 = ((64'd1 << RECIP_SH) + 64'd4094) / 64'd4095;
	localparam logic [RECIP_W-1:0] RECIP_4095 = RECIP_W'(RECIP_4095_64);

	localparam logic [RMS_W-1:0] RMS_MAX = '1;

	typedef struct packed {
		logic [CUR_W-1:0] cur_a;
		logic [CUR_W-1:0] cur_b;
		logic [SQ_W-1:0]  sq_a;
		logic [SQ_W-1:0]  sq_b;
		logic [MV_W-1:0]  motor_mv;
		logic [MV_W-1:0]  batt_mv;
		logic [MV_W-1:0]  aux_mv_a;
		logic [MV_W-1:0]  aux_mv_b;
	} mcrw_item_t;

	// floor(num / 4095) by multiplication with the reciprocal.
	function automatic logic [QUO_W-1:0] div4095(input logic [NUM_W-1:0] num);
		logic [NUM_W+RECIP_W-1:0] prod;
		prod = {{RECIP_W{1'b0}}, num} * {{NUM_W{1'b0}}, RECIP_4095};
		return prod[RECIP_SH +: QUO_W];
	endfunction

endpackage

>>> hdl/mcrw_front.sv
module mcrw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mcrw_pkg::IN_TDATA_W-1:0]     in_data,
	input  logic [mcrw_pkg::OFS_W-1:0]          offset_a,
	input  logic [mcrw_pkg::OFS_W-1:0]          offset_b,
	input  logic                                fifo_full,
	output logic                                push,
	output mcrw_pkg::mcrw_item_t                push_item
);
	import mcrw_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic accept;

	logic [RAW_W-1:0] raw [NUM_FIELDS];
	logic [NUM_W-1:0] num_c [NUM_FIELDS];
	logic [12:0]      aux_d [2];
	logic [NUM_W-1:0] aux_n [2];

	logic [NUM_W-1:0] num_s1 [NUM_FIELDS];
	logic [1:0]       neg_s1;
	logic [QUO_W-1:0] q_s2 [NUM_FIELDS];
	logic [1:0]       neg_s2;

	logic [17:0]      cw_a, cw_b;
	logic [CUR_W-1:0] mag_a_full, mag_b_full, aux_a_full, aux_b_full;

	logic [CUR_W-1:0] cur_a_s3, cur_b_s3;
	logic [MAG_W-1:0] mag_a_s3, mag_b_s3;
	logic [MV_W-1:0]  motor_s3, batt_s3, aux_a_s3, aux_b_s3;

	mcrw_item_t item_s4;

	// One word at a time runs through the four stages.
	assign in_ready = !(v_s1 || v_s2 || v_s3 || v_s4) && !fifo_full;
	assign accept = in_valid && in_ready;
	assign push = v_s4;
	assign push_item = item_s4;

	always_comb begin
		for (int i = 0; i < NUM_FIELDS; i++) begin
			raw[i] = in_data[i*RAW_W +: RAW_W];
		end
		num_c[0] = NUM_W'(raw[0]) * NUM_W'(CUR_SCALE);
		num_c[1] = NUM_W'(raw[1]) * NUM_W'(CUR_SCALE);
		num_c[2] = NUM_W'(raw[2]) * NUM_W'(VOLT_SCALE);
		num_c[3] = NUM_W'(raw[3]) * NUM_W'(VOLT_SCALE);
		// Bipolar inputs: divide the magnitude and restore the sign later,
		// so the quotient truncates toward zero.
		for (int i = 0; i < 2; i++) begin
			aux_d[i] = {1'b0, raw[4+i]} - 13'(AUX_MID);
			aux_n[i] = {{(NUM_W-13){aux_d[i][12]}}, aux_d[i]} * NUM_W'(VOLT_SCALE)
				+ NUM_W'(AUX_MID);
			num_c[4+i] = aux_n[i][NUM_W-1] ? (NUM_W'(0) - aux_n[i]) : aux_n[i];
		end
	end

	always_comb begin
		cw_a = {2'b00, q_s2[0]} - 18'(CUR_BIAS) - {{(18-OFS_W){offset_a[OFS_W-1]}}, offset_a};
		cw_b = {2'b00, q_s2[1]} - 18'(CUR_BIAS) - {{(18-OFS_W){offset_b[OFS_W-1]}}, offset_b};
		mag_a_full = cw_a[CUR_W-1] ? (CUR_W'(0) - cw_a[CUR_W-1:0]) : cw_a[CUR_W-1:0];
		mag_b_full = cw_b[CUR_W-1] ? (CUR_W'(0) - cw_b[CUR_W-1:0]) : cw_b[CUR_W-1:0];
		aux_a_full = neg_s2[0] ? (CUR_W'(0) - q_s2[4]) : q_s2[4];
		aux_b_full = neg_s2[1] ? (CUR_W'(0) - q_s2[5]) : q_s2[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_s1 <= num_c;
			neg_s1 <= {aux_n[1][NUM_W-1], aux_n[0][NUM_W-1]};
		end
		if (v_s1) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				q_s2[i] <= div4095(num_s1[i]);
			end
			neg_s2 <= neg_s1;
		end
		if (v_s2) begin
			cur_a_s3 <= cw_a[CUR_W-1:0];
			cur_b_s3 <= cw_b[CUR_W-1:0];
			mag_a_s3 <= mag_a_full[MAG_W-1:0];
			mag_b_s3 <= mag_b_full[MAG_W-1:0];
			motor_s3 <= q_s2[2][MV_W-1:0];
			batt_s3  <= q_s2[3][MV_W-1:0];
			aux_a_s3 <= aux_a_full[MV_W-1:0];
			aux_b_s3 <= aux_b_full[MV_W-1:0];
		end
		if (v_s3) begin
			item_s4.cur_a    <= cur_a_s3;
			item_s4.cur_b    <= cur_b_s3;
			item_s4.sq_a     <= {{(SQ_W-MAG_W){1'b0}}, mag_a_s3} * {{(SQ_W-MAG_W){1'b0}}, mag_a_s3};
			item_s4.sq_b     <= {{(SQ_W-MAG_W){1'b0}}, mag_b_s3} * {{(SQ_W-MAG_W){1'b0}}, mag_b_s3};
			item_s4.motor_mv <= motor_s3;
			item_s4.batt_mv  <= batt_s3;
			item_s4.aux_mv_a <= aux_a_s3;
			item_s4.aux_mv_b <= aux_b_s3;
		end
	end

endmodule

>>> hdl/mcrw_fifo.sv
`include "motor_current_rms_window_macros.svh"

module mcrw_fifo #(
	parameter int DEPTH = mcrw_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mcrw_pkg::mcrw_item_t push_item,
	input  logic                 pop,
	output mcrw_pkg::mcrw_item_t pop_item,
	output logic                 full,
	output logic                 empty
);
	import mcrw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mcrw_item_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	`MCRW_NEVER(a_push_full, push && full, "word pushed into a full queue")
	`MCRW_NEVER(a_pop_empty, pop && empty, "word popped from an empty queue")
	`MCRW_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

>>> hdl/mcrw_isqrt.sv
module mcrw_isqrt #(
	parameter int W = 40
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   value,
	output logic           busy,
	output logic           done,
	output logic [W/2-1:0] root
);

	logic [W-1:0] rem_q, res_q, bit_q;
	logic [W-1:0] trial, rem_n, res_n;
	logic         busy_q, done_q;

	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[W/2-1:0];

	// One result bit per cycle, classic digit-by-digit root.
	always_comb begin
		trial = res_q + bit_q;
		if (rem_q >= trial) begin
			rem_n = rem_q - trial;
			res_n = (res_q >> 1) + bit_q;
		end else begin
			rem_n = rem_q;
			res_n = res_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= {2'b01, {(W-2){1'b0}}};
		end else if (busy_q) begin
			rem_q <= rem_n;
			res_q <= res_n;
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> hdl/mcrw_back.sv
`include "motor_current_rms_window_macros.svh"

module mcrw_back #(
	parameter int SAMPLES_PER_WINDOW = mcrw_pkg::SPW_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               empty,
	output logic                               pop,
	input  mcrw_pkg::mcrw_item_t               item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mcrw_pkg::OUT_TDATA_W-1:0]   out_data,
	output logic                               out_done
);
	import mcrw_pkg::*;

	localparam int SPW = SAMPLES_PER_WINDOW;
	localparam int CLOG = $clog2(SPW);
	localparam int CNT_W = CLOG;
	localparam int ACC_W = TERM_W + CLOG;
	localparam int RT_W = ACC_W + (ACC_W % 2);
	localparam int ROOT_W = RT_W / 2;
	localparam int K10 = ROOT_W + 4;
	localparam int R10_W = K10 - 2;
	localparam int Q10_W = ROOT_W - 3;
	localparam int CMP_W = (Q10_W > RMS_W) ? Q10_W : RMS_W;
	localparam logic [63:0] RECIP10_64 = ((64'd1 << K10) + 64'(RMS_DIV) - 64'd1) / 64'(RMS_DIV);
	localparam logic [R10_W-1:0] RECIP10 = R10_W'(RECIP10_64);
	localparam int CS_W = CUR_W + CLOG;
	localparam int ABS_W = CS_W - 1;
	localparam int KA = ABS_W + CLOG;
	localparam logic [63:0] RECIPA_64 = ((64'd1 << KA) + 64'(SPW) - 64'd1) / 64'(SPW);
	localparam logic [KA-1:0] RECIP_AVG = KA'(RECIPA_64);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ROOT = 4'b0010,
		S_WAIT = 4'b0100,
		S_FIN  = 4'b1000
	} back_state_t;

	back_state_t state_q;

	logic [CNT_W-1:0] cnt_q;
	logic [SQ_W-1:0]  prev_a_q, prev_b_q;
	logic [ACC_W-1:0] acc_a_q, acc_b_q;
	logic [CS_W-1:0]  csum_a_q, csum_b_q;
	logic [RMS_W-1:0] rms_a_q, rms_b_q;
	logic [CUR_W-1:0] avg_a_q, avg_b_q;
	logic             out_valid_q, done_q;
	logic [CUR_W-1:0] cur_a_q, cur_b_q;
	logic [MV_W-1:0]  motor_q, batt_q, aux_a_q, aux_b_q;

	logic              out_free;
	logic [SQ_W:0]     sum_a, sum_b;
	logic [TERM_W-1:0] term_a, term_b;
	logic [ACC_W-1:0]  acc_a_n, acc_b_n;
	logic [CS_W-1:0]   csum_a_n, csum_b_n;
	logic              last_sample;

	logic              sqrt_start;
	logic              busy_a, busy_b, done_a, done_b;
	logic [ROOT_W-1:0] root_a, root_b;

	logic [ABS_W-1:0]      abs_a, abs_b;
	logic [ABS_W+KA-1:0]   aprod_a_q, aprod_b_q;
	logic [ROOT_W+R10_W-1:0] rprod_a, rprod_b;
	logic [CMP_W-1:0]      q10_a, q10_b;
	logic [CUR_W-1:0]      aq_a, aq_b;

	assign out_free = !out_valid_q || out_ready;
	assign pop = (state_q == S_IDLE) && !empty && out_free;
	assign last_sample = (cnt_q == CNT_W'(SPW - 1));
	assign sqrt_start = (state_q == S_ROOT);

	always_comb begin
		// Trapezoid term (I^2 + Iprev^2) * 5 as a sum and a shifted sum.
		sum_a = {1'b0, item.sq_a} + {1'b0, prev_a_q};
		sum_b = {1'b0, item.sq_b} + {1'b0, prev_b_q};
		term_a = {2'b00, sum_a} + {sum_a, 2'b00};
		term_b = {2'b00, sum_b} + {sum_b, 2'b00};
		acc_a_n = acc_a_q + {{CLOG{1'b0}}, term_a};
		acc_b_n = acc_b_q + {{CLOG{1'b0}}, term_b};
		csum_a_n = csum_a_q + {{CLOG{item.cur_a[CUR_W-1]}}, item.cur_a};
		csum_b_n = csum_b_q + {{CLOG{item.cur_b[CUR_W-1]}}, item.cur_b};
	end

	always_comb begin
		abs_a = csum_a_q[CS_W-1] ? ABS_W'(CS_W'(0) - csum_a_q) : csum_a_q[ABS_W-1:0];
		abs_b = csum_b_q[CS_W-1] ? ABS_W'(CS_W'(0) - csum_b_q) : csum_b_q[ABS_W-1:0];
		rprod_a = {{R10_W{1'b0}}, root_a} * {{ROOT_W{1'b0}}, RECIP10};
		rprod_b = {{R10_W{1'b0}}, root_b} * {{ROOT_W{1'b0}}, RECIP10};
		q10_a = CMP_W'(rprod_a[K10 +: Q10_W]);
		q10_b = CMP_W'(rprod_b[K10 +: Q10_W]);
		aq_a = {1'b0, aprod_a_q[KA +: CUR_W-1]};
		aq_b = {1'b0, aprod_b_q[KA +: CUR_W-1]};
	end

	mcrw_isqrt #(.W(RT_W)) u_isqrt_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (RT_W'(acc_a_q)),
		.busy   (busy_a),
		.done   (done_a),
		.root   (root_a)
	);

	mcrw_isqrt #(.W(RT_W)) u_isqrt_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (RT_W'(acc_b_q)),
		.busy   (busy_b),
		.done   (done_b),
		.root   (root_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			prev_a_q    <= '0;
			prev_b_q    <= '0;
			acc_a_q     <= '0;
			acc_b_q     <= '0;
			csum_a_q    <= '0;
			csum_b_q    <= '0;
			rms_a_q     <= '0;
			rms_b_q     <= '0;
			avg_a_q     <= '0;
			avg_b_q     <= '0;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						prev_a_q <= item.sq_a;
						prev_b_q <= item.sq_b;
						acc_a_q  <= acc_a_n;
						acc_b_q  <= acc_b_n;
						csum_a_q <= csum_a_n;
						csum_b_q <= csum_b_n;
						if (last_sample) begin
							cnt_q       <= '0;
							out_valid_q <= 1'b0;
							state_q     <= S_ROOT;
						end else begin
							cnt_q       <= cnt_q + 1'b1;
							out_valid_q <= 1'b1;
							done_q      <= 1'b0;
						end
					end
				end
				S_ROOT: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (done_a && done_b) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					rms_a_q <= (q10_a > CMP_W'(RMS_MAX)) ? RMS_MAX : q10_a[RMS_W-1:0];
					rms_b_q <= (q10_b > CMP_W'(RMS_MAX)) ? RMS_MAX : q10_b[RMS_W-1:0];
					avg_a_q <= csum_a_q[CS_W-1] ? (CUR_W'(0) - aq_a) : aq_a;
					avg_b_q <= csum_b_q[CS_W-1] ? (CUR_W'(0) - aq_b) : aq_b;
					acc_a_q <= '0;
					acc_b_q <= '0;
					csum_a_q <= '0;
					csum_b_q <= '0;
					out_valid_q <= 1'b1;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_a_q <= item.cur_a;
			cur_b_q <= item.cur_b;
			motor_q <= item.motor_mv;
			batt_q  <= item.batt_mv;
			aux_a_q <= item.aux_mv_a;
			aux_b_q <= item.aux_mv_b;
		end
		if (state_q == S_ROOT) begin
			aprod_a_q <= {{KA{1'b0}}, abs_a} * {{ABS_W{1'b0}}, RECIP_AVG};
			aprod_b_q <= {{KA{1'b0}}, abs_b} * {{ABS_W{1'b0}}, RECIP_AVG};
		end
	end

	assign out_valid = out_valid_q;
	assign out_done = done_q;
	assign out_data = {{(OUT_TDATA_W - 4*CUR_W - 6*MV_W){1'b0}},
		avg_b_q, avg_a_q, rms_b_q, rms_a_q, aux_b_q, aux_a_q, batt_q, motor_q, cur_b_q, cur_a_q};

	`MCRW_ASSERT(a_fin_emits, (state_q == S_FIN) |=> (out_valid_q && done_q && cnt_q == '0),
		"window close did not present a result")
	`MCRW_ASSERT(a_root_runs, (state_q == S_ROOT) |=> (busy_a && busy_b),
		"root units did not start")
	`MCRW_ASSERT(a_hold_stable, (out_valid_q && !out_ready) |=> ($stable(rms_a_q) && $stable(avg_b_q)),
		"held results changed under a stalled word")

endmodule

>>> hdl/motor_current_rms_window.sv
// Channel   Direction  Contents (low bit first)
// s_axis    in         current_raw_a, current_raw_b, motor_volt_raw, batt_volt_raw,
//                      aux_raw_a, aux_raw_b (12 bits each)
// m_axis    out        scaled currents, voltages, bipolar inputs, held RMS and average;
//                      tuser carries window_done
// cfg       in         register index and data: 0 offset_a, 1 offset_b (13-bit signed)
//
// The front takes a new word only when its four pipeline stages of constant scaling,
// reciprocal division by 4095 and squaring are empty and the queue is not full;
// each word then enters the queue. The back consumes a queued word while idle with
// its output free; a word that closes a window waits for both root units.
// Reset clears the offsets, window accumulators, previous squares and held results.
// s_axis_tready drops while the front holds a word or the queue is full; the queue
// fills when m_axis_tready is held low.
module motor_current_rms_window #(
	parameter int SAMPLES_PER_WINDOW = mcrw_pkg::SPW_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// current_raw_a, current_raw_b, motor_volt_raw, batt_volt_raw, aux_raw_a, aux_raw_b
	input  logic [mcrw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// current_ma_a, current_ma_b, motor_mv, batt_mv, aux_mv_a, aux_mv_b,
	// rms_a, rms_b, avg_a, avg_b, then zero fill
	output logic [mcrw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// window_done
	output logic                               m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mcrw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcrw_pkg::OFS_W-1:0]         cfg_data
);
	import mcrw_pkg::*;

	logic [OFS_W-1:0] offset_a_q, offset_b_q;
	logic             push, pop, full, empty;
	mcrw_item_t       push_item, pop_item;

	// Offsets must be written only while the block is idle, so no shadowing; not enforced here.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_a_q <= '0;
			offset_b_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OFFSET_A: offset_a_q <= cfg_data;
				REG_OFFSET_B: offset_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: scales each word and forms the squared currents.
	mcrw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.offset_a  (offset_a_q),
		.offset_b  (offset_b_q),
		.fifo_full (full),
		.push      (push),
		.push_item (push_item)
	);

	// Short queue between the two halves.
	mcrw_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (full),
		.empty     (empty)
	);

	// Back: window accumulation, RMS and average, output register.
	mcrw_back #(.SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.item      (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_done  (m_axis_tuser)
	);

endmodule
